[sv/pdh_pkg.sv]
// Shared types, constants and helper functions for the position density histogram.
package pdh_pkg;

	// Field widths of the request and result channels.
	localparam int FRAC_IN_W  = 16;
	localparam int SPECIES_W  = 7;
	localparam int GRID_W     = 7;
	localparam int BIN_W      = 6;
	localparam int DENS_FRAC  = 16;
	localparam int DENS_W     = DENS_FRAC + 1;

	// Row index (second axis plus z) and full flat bin address.
	localparam int ROW_W      = 2 * BIN_W;
	localparam int ADDR_W     = 3 * BIN_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// Serial multiplier walks the 7 bits of a grid operand.
	localparam int MUL_CNT_W  = $clog2(GRID_W);
	// Divider produces one quotient bit per cycle.
	localparam int DIV_CNT_W  = $clog2(DENS_FRAC);

	// Parameter defaults.
	localparam int MAX_CELLS_DEF   = 4096;
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;

	// Reset value of the grid size registers.
	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(50);
	localparam logic [GRID_W-1:0] GRID_MAX   = GRID_W'(64);

	// Density when the bin count reaches or exceeds the total.
	localparam logic [DENS_W-1:0] DENS_ONE = DENS_W'(1) << DENS_FRAC;

	// Request kinds.
	typedef enum logic {
		ACT_ADD  = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	// Plane choices for 2D binning; the unused code falls back to XY.
	typedef enum logic [1:0] {
		PLANE_XY = 2'd0,
		PLANE_XZ = 2'd1,
		PLANE_YZ = 2'd2
	} plane_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE_3D    = 3'd0,
		REG_PLANE_SEL  = 3'd1,
		REG_GRID_X     = 3'd2,
		REG_GRID_Y     = 3'd3,
		REG_GRID_Z     = 3'd4,
		REG_SPECIES    = 3'd5
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BIN_X,
		ST_BIN_Y,
		ST_BIN_Z,
		ST_ROW,
		ST_COL,
		ST_RD,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} state_t;

	// Grid size as used: zero counts as one, anything above 64 as 64.
	function automatic logic [GRID_W-1:0] eff_size(input logic [GRID_W-1:0] v);
		logic [GRID_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = GRID_W'(1);
		end else if (v > GRID_MAX) begin
			r = GRID_MAX;
		end
		return r;
	endfunction

endpackage

[sv/position_density_histogram_unit.sv]
// Top level of the position density histogram: bit-serial binning, bin store and divider.
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_stall  action, frac_x, frac_y, frac_z, species_code
//   out      result     out_valid/out_stall  bin_x, bin_y, bin_z, density, last_bin
//   cfg      write      cfg_we               cfg_index, cfg_data
//
// After an add request is taken, in_stall stays high, in 3D mode and on a plane alike:
// each bin index and each address term comes from a 7-step shift-add multiplier,
// then one read and one write of the bin store. An add that the species filter rejects
// causes no stall. A read request also holds in_stall, through the lookup and, unless
// the zero total and full-scale cases skip it, the restoring divider that forms
// count/total one quotient bit per cycle. After reset the bin store is cleared one
// entry per cycle, with in_stall held high. A finished result waits in the output register
// while the next request is taken; only a second result stalls behind an unaccepted one.
module position_density_histogram_unit #(
	parameter int MAX_CELLS   = pdh_pkg::MAX_CELLS_DEF,
	parameter int COUNT_WIDTH = pdh_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = pdh_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [pdh_pkg::FRAC_IN_W-1:0]     frac_x,
	input  logic [pdh_pkg::FRAC_IN_W-1:0]     frac_y,
	input  logic [pdh_pkg::FRAC_IN_W-1:0]     frac_z,
	input  logic [pdh_pkg::SPECIES_W-1:0]     species_code,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pdh_pkg::BIN_W-1:0]         bin_x,
	output logic [pdh_pkg::BIN_W-1:0]         bin_y,
	output logic [pdh_pkg::BIN_W-1:0]         bin_z,
	output logic [pdh_pkg::DENS_W-1:0]        density,
	output logic                              last_bin,
	// Configuration port.
	input  logic                              cfg_we,
	input  logic [pdh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdh_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pdh_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	localparam int MA = (FRAC_BITS > ROW_W) ? FRAC_BITS : ROW_W;
	localparam int PW = MA + GRID_W;
	localparam logic [AW-1:0]       CLR_LAST   = AW'(MAX_CELLS - 1);
	localparam logic [ADDR_W:0]     CELL_LIMIT = (ADDR_W + 1)'(MAX_CELLS);
	localparam logic [MUL_CNT_W-1:0] MUL_LAST  = MUL_CNT_W'(GRID_W - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DENS_FRAC - 1);

	// Coordinate bits used for binning: the low FRAC_BITS bits, zero extended.
	function automatic logic [FRAC_BITS-1:0] frac_ext(input logic [FRAC_IN_W-1:0] c);
		return FRAC_BITS'({{FRAC_BITS{1'b0}}, c});
	endfunction

	// Configuration registers.
	logic                 mode_3d_q;
	logic [1:0]           plane_sel_q;
	logic [GRID_W-1:0]    grid_x_q, grid_y_q, grid_z_q;
	logic [SPECIES_W-1:0] species_sel_q;

	// Histogram state.
	logic [COUNT_WIDTH-1:0] atom_total_q;
	logic [BIN_W-1:0]       read_x_q, read_y_q, read_z_q;
	logic [COUNT_WIDTH-1:0] bin_mem [MAX_CELLS];
	logic [COUNT_WIDTH-1:0] rd_data_q;

	// Sequencer and serial datapath.
	state_t                 state_q, state_d;
	logic [MUL_CNT_W-1:0]   mul_cnt_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [AW-1:0]          clr_idx_q;
	logic                   op_read_q;
	logic [FRAC_BITS-1:0]   f_lo_q, f_mid_q, f_hi_q;
	logic [BIN_W-1:0]       lo_q, mid_q, hi_q;
	logic [ROW_W-1:0]       row_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [PW-1:0]          prod_q;
	logic [COUNT_WIDTH-1:0] den_q, rem_q;
	logic [DENS_FRAC-1:0]   quo_q;
	logic [DENS_W-1:0]      dens_q;
	logic                   last_q;

	// Output register.
	logic                   out_valid_q;
	logic [BIN_W-1:0]       out_x_q, out_y_q, out_z_q;
	logic [DENS_W-1:0]      out_dens_q;
	logic                   out_last_q;

	// Combinational nets.
	logic [GRID_W-1:0]      gx, gy, gz;
	logic                   in_accept, species_ok, add_pass;
	logic                   end_x, end_y, end_z, read_last;
	logic                   mul_state, mul_done, div_done, out_free;
	logic [MA-1:0]          mul_a;
	logic [GRID_W-1:0]      mul_b;
	logic                   mul_bit;
	logic [PW-1:0]          prod_next;
	logic                   in_range;
	logic [COUNT_WIDTH-1:0] cnt_sel;
	logic                   cnt_full, short_div;
	logic [COUNT_WIDTH:0]   rem_dbl;
	logic                   rem_ge;
	logic [COUNT_WIDTH-1:0] rem_next;
	logic [DENS_FRAC-1:0]   quo_next;
	logic                   mem_we, mem_rd_en;
	logic [AW-1:0]          wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;

	// Effective grid sizes and request qualification.
	always_comb begin
		gx = eff_size(grid_x_q);
		gy = eff_size(grid_y_q);
		gz = eff_size(grid_z_q);
		in_accept  = in_valid && !in_stall;
		species_ok = (species_sel_q == '0) || (species_code == species_sel_q);
		add_pass   = (action == ACT_ADD) && species_ok;
	end

	// Readout position bookkeeping.
	always_comb begin
		end_x = (GRID_W'(read_x_q) + GRID_W'(1)) >= gx;
		end_y = (GRID_W'(read_y_q) + GRID_W'(1)) >= gy;
		end_z = mode_3d_q ? ((GRID_W'(read_z_q) + GRID_W'(1)) >= gz) : 1'b1;
		read_last = end_x && end_y && end_z;
	end

	// Shift-add multiplier, multiplier bits taken most significant first.
	always_comb begin
		mul_state = (state_q == ST_BIN_X) || (state_q == ST_BIN_Y) ||
		            (state_q == ST_BIN_Z) || (state_q == ST_ROW) || (state_q == ST_COL);
		mul_done  = mul_state && (mul_cnt_q == MUL_LAST);
		case (state_q)
			ST_BIN_X: begin
				mul_a = MA'(f_lo_q);
				mul_b = gx - GRID_W'(1);
			end
			ST_BIN_Y: begin
				mul_a = MA'(f_mid_q);
				mul_b = gy - GRID_W'(1);
			end
			ST_BIN_Z: begin
				mul_a = MA'(f_hi_q);
				mul_b = gz - GRID_W'(1);
			end
			ST_ROW: begin
				mul_a = MA'(hi_q);
				mul_b = gy;
			end
			ST_COL: begin
				mul_a = MA'(row_q);
				mul_b = gx;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_bit   = mul_b[MUL_LAST - mul_cnt_q];
		prod_next = ((mul_cnt_q == '0) ? '0 : {prod_q[PW-2:0], 1'b0}) +
		            (mul_bit ? PW'(mul_a) : '0);
	end

	// Bin lookup result and restoring divider step.
	always_comb begin
		in_range  = {1'b0, addr_q} < CELL_LIMIT;
		cnt_sel   = in_range ? rd_data_q : '0;
		cnt_full  = (rd_data_q == '1);
		short_div = (den_q == '0) || (cnt_sel >= den_q);
		rem_dbl   = {rem_q, 1'b0};
		rem_ge    = rem_dbl >= {1'b0, den_q};
		rem_next  = rem_ge ? COUNT_WIDTH'(rem_dbl - {1'b0, den_q}) : rem_dbl[COUNT_WIDTH-1:0];
		quo_next  = {quo_q[DENS_FRAC-2:0], rem_ge};
		div_done  = (state_q == ST_DIV) && (div_cnt_q == DIV_LAST);
		out_free  = !out_valid_q || !out_stall;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					if (action == ACT_READ) begin
						state_d = ST_ROW;
					end else if (species_ok) begin
						state_d = ST_BIN_X;
					end
				end
			end
			ST_BIN_X: begin
				if (mul_done) begin
					state_d = ST_BIN_Y;
				end
			end
			ST_BIN_Y: begin
				if (mul_done) begin
					state_d = mode_3d_q ? ST_BIN_Z : ST_ROW;
				end
			end
			ST_BIN_Z: begin
				if (mul_done) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				if (mul_done) begin
					state_d = ST_COL;
				end
			end
			ST_COL: begin
				if (mul_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_UPD;
			ST_UPD: begin
				if (!op_read_q) begin
					state_d = ST_IDLE;
				end else if (short_div) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		mem_rd_en = (state_q == ST_RD) && in_range;
		mem_we    = 1'b0;
		wr_addr   = addr_q[AW-1:0];
		wr_data   = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_idx_q;
			end
			ST_UPD: begin
				mem_we  = in_range && (op_read_q || !cnt_full);
				wr_data = op_read_q ? '0 : (rd_data_q + COUNT_WIDTH'(1));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Bin store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[wr_addr] <= wr_data;
		end
		if (mem_rd_en) begin
			rd_data_q <= bin_mem[addr_q[AW-1:0]];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_3d_q     <= 1'b0;
			plane_sel_q   <= PLANE_XY;
			grid_x_q      <= GRID_RESET;
			grid_y_q      <= GRID_RESET;
			grid_z_q      <= GRID_RESET;
			species_sel_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE_3D:   mode_3d_q     <= cfg_data[0];
				REG_PLANE_SEL: plane_sel_q   <= cfg_data[1:0];
				REG_GRID_X:    grid_x_q      <= cfg_data;
				REG_GRID_Y:    grid_y_q      <= cfg_data;
				REG_GRID_Z:    grid_z_q      <= cfg_data;
				REG_SPECIES:   species_sel_q <= cfg_data;
				default:       mode_3d_q     <= mode_3d_q;
			endcase
		end
	end

	// Sequencer, counters, atom total and readout position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			mul_cnt_q    <= '0;
			div_cnt_q    <= '0;
			clr_idx_q    <= '0;
			atom_total_q <= '0;
			read_x_q     <= '0;
			read_y_q     <= '0;
			read_z_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (mul_state) begin
				mul_cnt_q <= mul_done ? '0 : (mul_cnt_q + MUL_CNT_W'(1));
			end
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (in_accept && add_pass && (atom_total_q != '1)) begin
				atom_total_q <= atom_total_q + COUNT_WIDTH'(1);
			end
			if (in_accept && (action == ACT_READ)) begin
				if (read_last) begin
					read_x_q     <= '0;
					read_y_q     <= '0;
					read_z_q     <= '0;
					atom_total_q <= '0;
				end else if (!end_x) begin
					read_x_q <= read_x_q + BIN_W'(1);
				end else if (!end_y) begin
					read_x_q <= '0;
					read_y_q <= read_y_q + BIN_W'(1);
				end else begin
					read_x_q <= '0;
					read_y_q <= '0;
					read_z_q <= read_z_q + BIN_W'(1);
				end
			end
		end
	end

	// Request capture and serial datapath.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_read_q <= (action == ACT_READ);
			den_q     <= atom_total_q;
			last_q    <= read_last;
			if (action == ACT_READ) begin
				lo_q  <= read_x_q;
				mid_q <= read_y_q;
				hi_q  <= mode_3d_q ? read_z_q : '0;
			end else begin
				hi_q   <= '0;
				f_hi_q <= frac_ext(frac_z);
				if (mode_3d_q) begin
					f_lo_q  <= frac_ext(frac_x);
					f_mid_q <= frac_ext(frac_y);
				end else begin
					case (plane_sel_q)
						PLANE_XZ: begin
							f_lo_q  <= frac_ext(frac_x);
							f_mid_q <= frac_ext(frac_z);
						end
						PLANE_YZ: begin
							f_lo_q  <= frac_ext(frac_y);
							f_mid_q <= frac_ext(frac_z);
						end
						default: begin
							f_lo_q  <= frac_ext(frac_x);
							f_mid_q <= frac_ext(frac_y);
						end
					endcase
				end
			end
		end
		if (mul_state) begin
			prod_q <= prod_next;
		end
		if (mul_done) begin
			case (state_q)
				ST_BIN_X: lo_q   <= prod_next[FRAC_BITS +: BIN_W];
				ST_BIN_Y: mid_q  <= prod_next[FRAC_BITS +: BIN_W];
				ST_BIN_Z: hi_q   <= prod_next[FRAC_BITS +: BIN_W];
				ST_ROW:   row_q  <= prod_next[ROW_W-1:0] + ROW_W'(mid_q);
				ST_COL:   addr_q <= prod_next[ADDR_W-1:0] + ADDR_W'(lo_q);
				default:  row_q  <= row_q;
			endcase
		end
		// Division setup: zero total and full-scale cases finish at once.
		if ((state_q == ST_UPD) && op_read_q) begin
			rem_q <= cnt_sel;
			quo_q <= '0;
			if (den_q == '0) begin
				dens_q <= '0;
			end else if (cnt_sel >= den_q) begin
				dens_q <= DENS_ONE;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (div_done) begin
				dens_q <= {1'b0, quo_next};
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_x_q    <= lo_q;
			out_y_q    <= mid_q;
			out_z_q    <= hi_q;
			out_dens_q <= dens_q;
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_x     = out_x_q;
	assign bin_y     = out_y_q;
	assign bin_z     = out_z_q;
	assign density   = out_dens_q;
	assign last_bin  = out_last_q;

`ifndef SYNTHESIS
	// The partial remainder always stays below the divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder reached the divisor");

	// A counted atom leaves a nonzero total.
	a_total_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && add_pass) |=> (atom_total_q != '0))
		else $error("atom total is zero after a counted atom");

	// A new result appears only after the sequencer has finished a read request.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

	// The bin update always uses data from the lookup just before it.
	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $past(state_q == ST_RD))
		else $error("bin update without a preceding lookup");
`endif

endmodule
